### sv/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg: shared types for the lifo stack with search
// operation codes, status codes, command and result formats
// ----------------------------------------------------------------------------
package stk_pkg;

  // operation codes as carried on the input tuser
  typedef enum logic [2:0] {
    OP_QUERY  = 3'd0,
    OP_PUSH   = 3'd1,
    OP_POP    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_REFILL = 2'd1,
    S_SCAN   = 2'd2,
    S_EMIT   = 2'd3
  } state_t;

  // classified command, front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] data;
  } cmd_t;

  // result item, data_out in the lowest bits, zero pad to 48 bits
  typedef struct packed {
    logic [6:0]  pad;
    logic        is_full;
    logic        is_empty;
    logic [3:0]  count;
    logic        found;
    status_t     status;
    logic [31:0] data_out;
  } result_t;

endpackage

### sv/lifo_stack_with_search_unit.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_unit: fixed-depth lifo stack of 32-bit words
// push, pop, query, clear and search over the held entries
// ----------------------------------------------------------------------------
// usage
//   input stream: s_axis_tuser carries the operation, s_axis_tdata the word
//   to push or search for; one result item is produced for every input item
//   on the m_axis channel, in order
//   query, push, pop and clear are handled in the sequencer's idle state; the
//   result is registered once the command is at the queue head and the result register is free
//   a pop that leaves one or more entries passes through the refill state,
//   reloading the cached top word from the entry ram
//   search reads the entry ram one word per cycle through its single read
//   port, then presents the result once the result register is free
//   reset empties the stack; entry contents are kept but never read again
//   until overwritten, so no clearing pass is needed
//   a two-entry command queue takes items while the sequencer is busy; when
//   the receiver stalls the result register holds, the sequencer waits and
//   the queue backs up into s_axis_tready
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit
  import stk_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] data_in
  input  logic [2:0]  s_axis_tuser,  // [2:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] data_out, [33:32] status, [34] found, [38:35] count,
  // [39] is_empty, [40] is_full, [47:41] zero
  output logic [47:0] m_axis_tdata
);

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  result_t res;

  // front: classify and queue commands
  stk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: stack state, entry ram and result register
  stk_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = res;

endmodule

### sv/stk_ram.sv
// ----------------------------------------------------------------------------
// stk_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module stk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/stk_front.sv
// ----------------------------------------------------------------------------
// stk_front: input classifier and command queue
// maps operation codes (unknown codes become query) into a two-entry queue
// ----------------------------------------------------------------------------
module stk_front
  import stk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_data,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] num;
  cmd_t       cls;
  logic       push;

  // classification
  always_comb begin
    cls.data = in_data;
    case (in_func)
      OP_PUSH, OP_POP, OP_CLEAR, OP_SEARCH: cls.op = op_t'(in_func);
      default:                              cls.op = OP_QUERY;
    endcase
  end

  assign in_ready  = (num != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (num != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      num    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      num <= num + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

endmodule

### sv/stk_back.sv
// ----------------------------------------------------------------------------
// stk_back: stack execution sequencer
// keeps fill count and cached top, drives the entry ram, scans for search
// ----------------------------------------------------------------------------
module stk_back
  import stk_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [31:0]    top, top_next;
  logic           hit, hit_next;
  logic [CW-1:0]  scan_addr, scan_addr_next;
  logic [CW-1:0]  left, left_next;
  logic           res_valid_next;
  result_t        res_next;
  logic           res_free;
  logic           is_full_now;
  logic [CW-1:0]  cnt_inc;
  logic [CW-1:0]  cnt_dec;
  logic [CW-1:0]  cnt_dec2;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [31:0]    ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [31:0]    ram_rdata;

  function automatic result_t make_res(input logic [31:0] d, input status_t st,
                                       input logic f, input logic [CW-1:0] c);
    result_t r;
    r.pad      = '0;
    r.is_full  = (c == CW'(DEPTH));
    r.is_empty = (c == '0);
    r.count    = 4'(c);
    r.found    = f;
    r.status   = st;
    r.data_out = d;
    return r;
  endfunction

  stk_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_free    = !res_valid || res_ready;
  assign is_full_now = (count == CW'(DEPTH));
  assign cnt_inc     = count + CW'(1);
  assign cnt_dec     = count - CW'(1);
  assign cnt_dec2    = count - CW'(2);

  always_comb begin
    state_next     = state;
    count_next     = count;
    top_next       = top;
    hit_next       = hit;
    scan_addr_next = scan_addr;
    left_next      = left;
    res_valid_next = res_valid && !res_ready;
    res_next       = res;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = count[AW-1:0];
    ram_wdata      = cmd.data;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_PUSH: begin
              if (res_free) begin
                cmd_pop        = 1'b1;
                res_valid_next = 1'b1;
                if (is_full_now) begin
                  res_next = make_res(top, ST_FULL, 1'b0, count);
                end else begin
                  ram_we     = 1'b1;
                  top_next   = cmd.data;
                  count_next = cnt_inc;
                  res_next   = make_res(cmd.data, ST_OK, 1'b0, cnt_inc);
                end
              end
            end
            OP_POP: begin
              if (res_free) begin
                cmd_pop        = 1'b1;
                res_valid_next = 1'b1;
                if (count == '0) begin
                  res_next = make_res('0, ST_EMPTY, 1'b0, count);
                end else begin
                  count_next = cnt_dec;
                  res_next   = make_res(top, ST_OK, 1'b0, cnt_dec);
                  // fetch the entry below to become the new top
                  if (count > CW'(1)) begin
                    ram_re     = 1'b1;
                    ram_raddr  = cnt_dec2[AW-1:0];
                    state_next = S_REFILL;
                  end
                end
              end
            end
            OP_CLEAR: begin
              if (res_free) begin
                cmd_pop        = 1'b1;
                res_valid_next = 1'b1;
                count_next     = '0;
                res_next       = make_res('0, ST_OK, 1'b0, '0);
              end
            end
            OP_SEARCH: begin
              if (count == '0) begin
                if (res_free) begin
                  cmd_pop        = 1'b1;
                  res_valid_next = 1'b1;
                  res_next       = make_res('0, ST_EMPTY, 1'b0, count);
                end
              end else begin
                ram_re         = 1'b1;
                ram_raddr      = '0;
                scan_addr_next = CW'(1);
                left_next      = count;
                hit_next       = 1'b0;
                state_next     = S_SCAN;
              end
            end
            default: begin
              if (res_free) begin
                cmd_pop        = 1'b1;
                res_valid_next = 1'b1;
                if (count == '0) begin
                  res_next = make_res('0, ST_EMPTY, 1'b0, count);
                end else begin
                  res_next = make_res(top, ST_OK, 1'b0, count);
                end
              end
            end
          endcase
        end
      end
      S_REFILL: begin
        top_next   = ram_rdata;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        // one compare a cycle, next read issued alongside
        hit_next  = hit | (ram_rdata == cmd.data);
        left_next = left - CW'(1);
        if (scan_addr < count) begin
          ram_re         = 1'b1;
          ram_raddr      = scan_addr[AW-1:0];
          scan_addr_next = scan_addr + CW'(1);
        end
        if (left == CW'(1)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_free) begin
          cmd_pop        = 1'b1;
          res_valid_next = 1'b1;
          res_next       = make_res(top, ST_OK, hit, count);
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    top       <= top_next;
    hit       <= hit_next;
    scan_addr <= scan_addr_next;
    left      <= left_next;
    res       <= res_next;
  end

endmodule
